// ===== rtl/mqsb_pkg.sv =====
package mqsb_pkg;

    // Default sizes
    localparam int NUM_QUEUES_DEF = 8;
    localparam int NUM_SLOTS_DEF  = 256;
    localparam int FIFO_DEPTH     = 2;

    // Request codes
    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // Returned on a dequeue from an empty or out-of-range queue
    localparam logic signed [31:0] SENTINEL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic                req_type;
        logic [2:0]          queue_id;
        logic signed [31:0]  item_value;
    } t_req;

    typedef struct packed {
        logic signed [31:0]  data_out;
        logic [1:0]          status;
        logic                pool_full;
        logic                queue_empty;
    } t_rsp;

    // Classified request, handed from the front end to the engine
    typedef struct packed {
        logic                is_enq;
        logic                qvalid;
        logic [2:0]          queue_id;
        logic signed [31:0]  item_value;
    } t_cmd;

endpackage

// ===== rtl/mqsb_fifo.sv =====
module mqsb_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = mqsb_pkg::FIFO_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T               r_mem [DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [CW-1:0]  r_cnt;
    logic           w_wr;
    logic           w_rd;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= bump(r_wptr);
            end
            if (w_rd) begin
                r_rptr <= bump(r_rptr);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== rtl/mqsb_front.sv =====
module mqsb_front #(
    parameter int NUM_QUEUES = mqsb_pkg::NUM_QUEUES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mqsb_pkg::t_req  i_req,
    output logic            o_full,
    input  logic            i_pop,
    output mqsb_pkg::t_cmd  o_cmd,
    output logic            o_empty
);

    mqsb_pkg::t_cmd w_cmd;

    // Decode the operation and range-check the queue number up front
    assign w_cmd.is_enq     = (i_req.req_type == mqsb_pkg::REQ_ENQ);
    assign w_cmd.qvalid     = (32'(i_req.queue_id) < NUM_QUEUES);
    assign w_cmd.queue_id   = i_req.queue_id;
    assign w_cmd.item_value = i_req.item_value;

    mqsb_fifo #(
        .T     (mqsb_pkg::t_cmd),
        .DEPTH (mqsb_pkg::FIFO_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (o_cmd),
        .o_empty (o_empty)
    );

endmodule

// ===== rtl/mqsb_back.sv =====
module mqsb_back #(
    parameter int NUM_QUEUES = mqsb_pkg::NUM_QUEUES_DEF,
    parameter int NUM_SLOTS  = mqsb_pkg::NUM_SLOTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mqsb_pkg::t_cmd  i_cmd,
    input  logic            i_cmd_empty,
    output logic            o_cmd_pop,
    output mqsb_pkg::t_rsp  o_rsp,
    output logic            o_rsp_push,
    input  logic            i_rsp_full
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int LW = SW + 1;
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    localparam logic [LW-1:0] LINK_END = LW'(NUM_SLOTS);

    localparam logic S_ISSUE  = 1'b0;
    localparam logic S_COMMIT = 1'b1;

    logic                r_state;
    mqsb_pkg::t_cmd      r_cmd;
    logic [LW-1:0]       r_slot;
    logic                r_fail;
    logic                r_qnz;
    logic [LW-1:0]       r_link_rd;
    logic signed [31:0]  r_data_rd;
    logic [LW-1:0]       r_free_head;
    logic [LW-1:0]       r_hwm;
    logic [LW-1:0]       r_head [NUM_QUEUES];
    logic [SW-1:0]       r_tail [NUM_QUEUES];
    logic [LW-1:0]       r_link_mem [NUM_SLOTS];
    logic signed [31:0]  r_data_mem [NUM_SLOTS];

    logic [QW-1:0]       w_qi;
    logic [QW-1:0]       w_cqi;
    logic [LW-1:0]       w_head;
    logic                w_qnz;
    logic                w_start;
    logic [LW-1:0]       w_slot;
    logic                w_fail;
    logic                w_go;
    logic                w_commit;
    logic                w_fresh;
    logic [LW-1:0]       w_link_next;
    logic                w_lk_we;
    logic [SW-1:0]       w_lk_addr;
    logic [LW-1:0]       w_lk_wdata;

    // Issue cycle: pick the slot and start the memory reads
    assign w_qi    = QW'(i_cmd.queue_id);
    assign w_head  = r_head[w_qi];
    assign w_qnz   = i_cmd.qvalid && (w_head != LINK_END);
    assign w_start = (r_state == S_ISSUE) && !i_cmd_empty && !i_rsp_full;
    assign w_slot  = i_cmd.is_enq ? r_free_head : w_head;
    assign w_fail  = i_cmd.is_enq ? (!i_cmd.qvalid || (r_free_head == LINK_END)) : !w_qnz;
    assign w_go    = w_start && !w_fail;

    // Commit cycle: slots at or above the fill mark were never linked, so the next slot stands in for their link
    assign w_commit    = (r_state == S_COMMIT);
    assign w_cqi       = QW'(r_cmd.queue_id);
    assign w_fresh     = (r_slot >= r_hwm);
    assign w_link_next = w_fresh ? (r_slot + LW'(1)) : r_link_rd;

    // One link write per cycle: tail relink on issue, slot link on commit
    always_comb begin
        w_lk_we    = 1'b0;
        w_lk_addr  = r_slot[SW-1:0];
        w_lk_wdata = r_cmd.is_enq ? LINK_END : r_free_head;
        if (w_commit) begin
            w_lk_we = !r_fail;
        end else if (w_go && i_cmd.is_enq && w_qnz) begin
            w_lk_we    = 1'b1;
            w_lk_addr  = r_tail[w_qi];
            w_lk_wdata = w_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lk_we) begin
            r_link_mem[w_lk_addr] <= w_lk_wdata;
        end
        if (w_go) begin
            r_link_rd <= r_link_mem[w_slot[SW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && i_cmd.is_enq) begin
            r_data_mem[w_slot[SW-1:0]] <= i_cmd.item_value;
        end
        if (w_go) begin
            r_data_rd <= r_data_mem[w_slot[SW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ISSUE;
            r_free_head <= '0;
            r_hwm       <= '0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= LINK_END;
            end
        end else begin
            unique case (r_state)
                S_ISSUE: begin
                    if (w_start) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    r_state <= S_ISSUE;
                    if (!r_fail) begin
                        if (r_cmd.is_enq) begin
                            r_free_head <= w_link_next;
                            if (w_fresh) begin
                                r_hwm <= r_hwm + LW'(1);
                            end
                            if (!r_qnz) begin
                                r_head[w_cqi] <= r_slot;
                            end
                        end else begin
                            r_head[w_cqi] <= w_link_next;
                            r_free_head   <= r_slot;
                        end
                    end
                end
                default: r_state <= S_ISSUE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_cmd  <= i_cmd;
            r_slot <= w_slot;
            r_fail <= w_fail;
            r_qnz  <= w_qnz;
        end
        if (w_commit && !r_fail && r_cmd.is_enq) begin
            r_tail[w_cqi] <= r_slot[SW-1:0];
        end
    end

    always_comb begin
        o_rsp.data_out    = '0;
        o_rsp.status      = mqsb_pkg::ST_OK;
        o_rsp.pool_full   = (r_free_head == LINK_END);
        o_rsp.queue_empty = !r_qnz;
        if (r_cmd.is_enq) begin
            if (r_fail) begin
                o_rsp.status = mqsb_pkg::ST_OVERFLOW;
            end else begin
                o_rsp.pool_full   = (w_link_next == LINK_END);
                o_rsp.queue_empty = 1'b0;
            end
        end else begin
            if (r_fail) begin
                o_rsp.status   = mqsb_pkg::ST_UNDERFLOW;
                o_rsp.data_out = mqsb_pkg::SENTINEL_MAX;
            end else begin
                o_rsp.data_out    = r_data_rd;
                o_rsp.pool_full   = 1'b0;
                o_rsp.queue_empty = (w_link_next == LINK_END);
            end
        end
    end

    assign o_cmd_pop  = w_start;
    assign o_rsp_push = w_commit;

endmodule

// ===== rtl/multi_queue_shared_buffer_core.sv =====
// Several FIFO queues kept as linked lists in one shared pool of slots.
// Input channel (push/full, i_req): each item is an enqueue of item_value on
// queue queue_id, or a dequeue of that queue's oldest item. Result channel
// (empty/pop, o_rsp): one result per item, in order, carrying the dequeued
// value, a status (ok, overflow, underflow), and pool-full / queue-empty flags.
// The engine takes a new item only once it is done with the last one: it
// reads the link and data memories in its issue state and commits the
// pointer and link updates in its commit state, sharing the single link
// memory write port. A result passes the command queue, engine and result
// queue before it shows (empty low); a 2-entry command queue in front and a
// 2-entry result queue behind let either side stall without stopping the other.
// Reset (synchronous, active low) empties every queue and threads all slots
// onto the free list in order; it takes effect at once, with no clearing
// pass, since never-touched slots are tracked with a fill mark.
// When the receiver stops popping, the result queue fills, the engine holds,
// then the command queue fills and full rises.
module multi_queue_shared_buffer_core #(
    parameter int NUM_QUEUES = mqsb_pkg::NUM_QUEUES_DEF,
    parameter int NUM_SLOTS  = mqsb_pkg::NUM_SLOTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    input  mqsb_pkg::t_req  i_req,
    output logic            full,
    output logic            empty,
    input  logic            pop,
    output mqsb_pkg::t_rsp  o_rsp
);

    mqsb_pkg::t_cmd w_cmd;
    logic           w_cmd_empty;
    logic           w_cmd_pop;
    mqsb_pkg::t_rsp w_rsp;
    logic           w_rsp_push;
    logic           w_rsp_full;

    // Front end: classify the request and buffer it
    mqsb_front #(
        .NUM_QUEUES (NUM_QUEUES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (i_req),
        .o_full  (full),
        .i_pop   (w_cmd_pop),
        .o_cmd   (w_cmd),
        .o_empty (w_cmd_empty)
    );

    // Engine: walk the lists, advance heads, tails and the free list
    mqsb_back #(
        .NUM_QUEUES (NUM_QUEUES),
        .NUM_SLOTS  (NUM_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .o_rsp       (w_rsp),
        .o_rsp_push  (w_rsp_push),
        .i_rsp_full  (w_rsp_full)
    );

    // Result queue: hold finished results until the receiver pops them
    mqsb_fifo #(
        .T     (mqsb_pkg::t_rsp),
        .DEPTH (mqsb_pkg::FIFO_DEPTH)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rsp_push),
        .i_data  (w_rsp),
        .o_full  (w_rsp_full),
        .i_pop   (pop),
        .o_data  (o_rsp),
        .o_empty (empty)
    );

endmodule

// ===== rtl/mqsb_chk.sv =====
module mqsb_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            empty,
    input logic            pop,
    input mqsb_pkg::t_rsp  o_rsp
);

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending after reset");

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_rsp))
        else $error("stalled result changed");

    a_overflow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_rsp.status == mqsb_pkg::ST_OVERFLOW) |-> (o_rsp.data_out == '0))
        else $error("overflow result carries data");

    a_underflow_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_rsp.status == mqsb_pkg::ST_UNDERFLOW)
        |-> (o_rsp.data_out == mqsb_pkg::SENTINEL_MAX) && o_rsp.queue_empty)
        else $error("underflow result malformed");

endmodule

bind multi_queue_shared_buffer_core mqsb_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .o_rsp   (o_rsp)
);

// ===== tb/tb_multi_queue_shared_buffer_core.sv =====
module tb_multi_queue_shared_buffer_core;

    localparam int QUEUES       = mqsb_pkg::NUM_QUEUES_DEF;
    localparam int SLOTS        = mqsb_pkg::NUM_SLOTS_DEF;
    localparam logic [8:0] LINK_END = 9'(SLOTS);

    // Random part: six segments; each pairs an enqueue bias with an idling mode
    localparam int N_RAND       = 1650;
    localparam int SEG_LEN      = 275;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    // Bias of a random segment
    localparam int BIAS_FILL    = 0;
    localparam int BIAS_DRAIN   = 1;
    localparam int BIAS_MIXED   = 2;

    // Idling modes
    localparam int IDLE_NONE    = 0;
    localparam int IDLE_SENDER  = 1;
    localparam int IDLE_RECV    = 2;
    localparam int IDLE_BOTH    = 3;

    // Results that can be read off at a glance
    localparam mqsb_pkg::t_rsp RSP_EMPTY_DEQ =
        '{mqsb_pkg::SENTINEL_MAX, mqsb_pkg::ST_UNDERFLOW, 1'b0, 1'b1};
    localparam mqsb_pkg::t_rsp RSP_ENQ_OK    = '{32'sd0, mqsb_pkg::ST_OK, 1'b0, 1'b0};

    typedef struct {
        mqsb_pkg::t_req rq;
        bit             typed;
        mqsb_pkg::t_rsp rsp;
    } t_stim_row;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           push    = 1'b0;
    logic           pop     = 1'b0;
    mqsb_pkg::t_req i_req   = '0;
    logic           full;
    logic           empty;
    mqsb_pkg::t_rsp o_rsp;

    multi_queue_shared_buffer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .i_req   (i_req),
        .full    (full),
        .empty   (empty),
        .pop     (pop),
        .o_rsp   (o_rsp)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the slot pool, the per-queue pointers and the free list
    logic signed [31:0] pool_data [SLOTS];
    logic [8:0]         pool_link [SLOTS];
    logic [8:0]         q_head    [QUEUES];
    logic [8:0]         q_tail    [QUEUES];
    logic [8:0]         free_ptr;

    t_stim_row      dir_rows [$];
    mqsb_pkg::t_rsp rsp_expected [$];

    int             n_sent        = 0;
    int             n_total       = 0;
    int             n_errors      = 0;
    int             idle_mode     = IDLE_NONE;
    int             quiet_cycles  = 0;
    bit             cur_typed     = 1'b0;
    mqsb_pkg::t_rsp cur_typed_rsp = '0;

    function automatic bit in_pool(logic [8:0] p);
        return p < LINK_END;
    endfunction

    // Thread every slot onto the free list in order and empty all queues
    task automatic reset_pool();
        for (int i = 0; i < SLOTS; i++) begin
            pool_data[i] = '0;
            pool_link[i] = 9'(i + 1);
        end
        pool_link[SLOTS-1] = LINK_END;
        for (int i = 0; i < QUEUES; i++) begin
            q_head[i] = LINK_END;
            q_tail[i] = '0;
        end
        free_ptr = '0;
    endtask

    // Apply one request to the shadow pool and return the result it causes
    function automatic mqsb_pkg::t_rsp queue_op_result(mqsb_pkg::t_req r);
        mqsb_pkg::t_rsp rs;
        logic [8:0]     s;
        bit             qv;
        rs = '{32'sd0, mqsb_pkg::ST_OK, 1'b0, 1'b1};
        qv = int'(r.queue_id) < QUEUES;
        if (r.req_type == mqsb_pkg::REQ_ENQ) begin
            if (!qv || !in_pool(free_ptr)) begin
                rs.status = mqsb_pkg::ST_OVERFLOW;
            end else begin
                // take the free-list head and append it behind the tail
                s = free_ptr;
                free_ptr = pool_link[s];
                if (!in_pool(q_head[r.queue_id])) begin
                    q_head[r.queue_id] = s;
                end else if (in_pool(q_tail[r.queue_id])) begin
                    pool_link[q_tail[r.queue_id]] = s;
                end
                pool_link[s] = LINK_END;
                q_tail[r.queue_id] = s;
                pool_data[s] = r.item_value;
            end
        end else begin
            if (!qv || !in_pool(q_head[r.queue_id])) begin
                rs.status   = mqsb_pkg::ST_UNDERFLOW;
                rs.data_out = mqsb_pkg::SENTINEL_MAX;
            end else begin
                // unlink the head slot and push it onto the free list
                s = q_head[r.queue_id];
                q_head[r.queue_id] = pool_link[s];
                pool_link[s] = free_ptr;
                free_ptr = s;
                rs.data_out = pool_data[s];
            end
        end
        if (qv) rs.queue_empty = !in_pool(q_head[r.queue_id]);
        rs.pool_full = !in_pool(free_ptr);
        return rs;
    endfunction

    task automatic add_row(logic op, logic [2:0] q, logic signed [31:0] v, bit typed,
                           mqsb_pkg::t_rsp rsp);
        t_stim_row row;
        row.rq    = '{op, q, v};
        row.typed = typed;
        row.rsp   = rsp;
        dir_rows.push_back(row);
    endtask

    task automatic flag_result(bit orphan, mqsb_pkg::t_rsp want, mqsb_pkg::t_rsp got);
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
            if (orphan) begin
                $display("unexpected result: data %h status %0d full %b empty %b",
                         got.data_out, got.status, got.pool_full, got.queue_empty);
            end else begin
                $display("mismatch: data %h/%h status %0d/%0d full %b/%b empty %b/%b (exp/got)",
                         want.data_out, got.data_out, want.status, got.status,
                         want.pool_full, got.pool_full, want.queue_empty, got.queue_empty);
            end
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Sender: predict each accepted item, hold a refused one, then pick the next
    always @(posedge i_clk) begin
        mqsb_pkg::t_req nxt;
        mqsb_pkg::t_rsp pred;
        int             seg;
        int             mode;
        int             bias;
        int             enq_pct;
        if (!i_rst_n) begin
            reset_pool();
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                pred = queue_op_result(i_req);
                rsp_expected.push_back(cur_typed ? cur_typed_rsp : pred);
                n_sent++;
            end
            // directed rows run with no idling
            seg  = (n_sent < dir_rows.size()) ? -1 : (n_sent - dir_rows.size()) / SEG_LEN;
            mode = (seg < 0) ? IDLE_NONE : seg % 4;
            bias = (seg < 0) ? BIAS_MIXED : seg % 3;
            idle_mode <= mode;
            if (push && full) begin
                // hold the refused item on the port
            end else if (n_sent >= n_total) begin
                push <= 1'b0;
            end else if ((mode == IDLE_SENDER && $urandom_range(0, 99) < 83) ||
                         (mode == IDLE_BOTH && $urandom_range(0, 99) < 28)) begin
                push <= 1'b0;
            end else begin
                if (seg < 0) begin
                    nxt           = dir_rows[n_sent].rq;
                    cur_typed     = dir_rows[n_sent].typed;
                    cur_typed_rsp = dir_rows[n_sent].rsp;
                end else begin
                    // fill segments drive the pool into overflow, drain ones into underflow
                    enq_pct = (bias == BIAS_FILL) ? 97 : (bias == BIAS_DRAIN) ? 3 : 50;
                    nxt.req_type   = ($urandom_range(0, 99) < enq_pct) ?
                                     mqsb_pkg::REQ_ENQ : mqsb_pkg::REQ_DEQ;
                    nxt.queue_id   = 3'($urandom_range(0, QUEUES - 1));
                    nxt.item_value = pick_value();
                    cur_typed      = 1'b0;
                end
                i_req <= nxt;
                push  <= 1'b1;
            end
        end
    end

    // Receiver: check each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        mqsb_pkg::t_rsp want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (rsp_expected.size() == 0) begin
                    flag_result(1'b1, '0, o_rsp);
                end else begin
                    want = rsp_expected.pop_front();
                    if (o_rsp.data_out !== want.data_out || o_rsp.status !== want.status ||
                        o_rsp.pool_full !== want.pool_full ||
                        o_rsp.queue_empty !== want.queue_empty) begin
                        flag_result(1'b0, want, o_rsp);
                    end
                end
            end
            pop <= !((idle_mode == IDLE_RECV && $urandom_range(0, 99) < 83) ||
                     (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 28));
        end
    end

    // Watchdog: count cycles in which neither side moves an item
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        // dequeue before anything was written: underflow on both ends of the id range
        add_row(mqsb_pkg::REQ_DEQ, 3'd0, 32'sd0, 1'b1, RSP_EMPTY_DEQ);
        add_row(mqsb_pkg::REQ_DEQ, 3'd7, 32'sh7FFF_FFFF, 1'b1, RSP_EMPTY_DEQ);
        // extreme items on the extreme queues
        add_row(mqsb_pkg::REQ_ENQ, 3'd0, 32'sh7FFF_FFFF, 1'b1, RSP_ENQ_OK);
        add_row(mqsb_pkg::REQ_ENQ, 3'd0, 32'sh8000_0000, 1'b1, RSP_ENQ_OK);
        add_row(mqsb_pkg::REQ_ENQ, 3'd7, -32'sd1, 1'b1, RSP_ENQ_OK);
        add_row(mqsb_pkg::REQ_ENQ, 3'd7, 32'sd0, 1'b1, RSP_ENQ_OK);
        add_row(mqsb_pkg::REQ_DEQ, 3'd0, 32'sd0, 1'b1,
                '{32'sh7FFF_FFFF, mqsb_pkg::ST_OK, 1'b0, 1'b0});
        add_row(mqsb_pkg::REQ_DEQ, 3'd0, -32'sd1, 1'b1,
                '{32'sh8000_0000, mqsb_pkg::ST_OK, 1'b0, 1'b1});
        add_row(mqsb_pkg::REQ_DEQ, 3'd0, 32'sd0, 1'b1, RSP_EMPTY_DEQ);
        add_row(mqsb_pkg::REQ_DEQ, 3'd7, 32'sd0, 1'b1,
                '{-32'sd1, mqsb_pkg::ST_OK, 1'b0, 1'b0});
        add_row(mqsb_pkg::REQ_DEQ, 3'd7, 32'sd0, 1'b1,
                '{32'sd0, mqsb_pkg::ST_OK, 1'b0, 1'b1});
        add_row(mqsb_pkg::REQ_DEQ, 3'd7, 32'sd0, 1'b1, RSP_EMPTY_DEQ);
        // interleave queues so freed slots come back out of order
        add_row(mqsb_pkg::REQ_ENQ, 3'd1, 32'sh5555_5555, 1'b0, '0);
        add_row(mqsb_pkg::REQ_ENQ, 3'd2, 32'shAAAA_AAAA, 1'b0, '0);
        add_row(mqsb_pkg::REQ_ENQ, 3'd3, 32'sh0000_0001, 1'b0, '0);
        add_row(mqsb_pkg::REQ_ENQ, 3'd4, 32'sh4000_0000, 1'b0, '0);
        add_row(mqsb_pkg::REQ_ENQ, 3'd5, 32'shFFFF_FFFE, 1'b0, '0);
        add_row(mqsb_pkg::REQ_ENQ, 3'd6, 32'sh1234_5678, 1'b0, '0);
        add_row(mqsb_pkg::REQ_ENQ, 3'd3, 32'sh0F0F_0F0F, 1'b0, '0);
        add_row(mqsb_pkg::REQ_DEQ, 3'd2, 32'sd0, 1'b0, '0);
        add_row(mqsb_pkg::REQ_DEQ, 3'd3, 32'sd0, 1'b0, '0);
        add_row(mqsb_pkg::REQ_ENQ, 3'd5, 32'shF0F0_F0F0, 1'b0, '0);
        add_row(mqsb_pkg::REQ_DEQ, 3'd3, 32'sd0, 1'b0, '0);
        add_row(mqsb_pkg::REQ_DEQ, 3'd3, 32'sd0, 1'b0, '0);
        add_row(mqsb_pkg::REQ_DEQ, 3'd5, 32'sd0, 1'b0, '0);
        n_total = dir_rows.size() + N_RAND;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample at the falling edge, after every rising-edge update has settled
        do begin
            @(negedge i_clk);
        end while (!(n_sent >= n_total && rsp_expected.size() == 0) &&
                   quiet_cycles < QUIET_LIMIT);

        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            // let any stray result show up before the verdict
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            @(negedge i_clk);
            if (n_errors == 0 && rsp_expected.size() == 0) begin
                $display("DONE: 0 errors");
            end else begin
                $display("DONE: errors detected");
            end
            $finish;
        end
    end

endmodule

// ===== files.f =====
rtl/mqsb_pkg.sv
rtl/mqsb_fifo.sv
rtl/mqsb_front.sv
rtl/mqsb_back.sv
rtl/multi_queue_shared_buffer_core.sv
rtl/mqsb_chk.sv
tb/tb_multi_queue_shared_buffer_core.sv
